[src/agf_pkg.sv]
// Package for the ADC glitch filter: widths, defaults, register indexes,
// controller states and the command/status/config structs.
// No dependencies.
package agf_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int CHAN_W         = 3;
    localparam int DEF_CHANNELS   = 6;
    localparam int DEF_RING_DEPTH = 8;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [SAMPLE_W-1:0] HYST_RESET   = 12'd64;
    localparam logic                ENABLE_RESET = 1'b1;

    localparam logic REG_HYST   = 1'b0;
    localparam logic REG_ENABLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_HIT,
        ST_MISS,
        ST_CP_RD,
        ST_CP_WR,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_MEAN,
        ST_DONE
    } agf_state_t;

    typedef struct packed {
        logic load;
        logic srch_rd;
        logic srch_next;
        logic hit_upd;
        logic miss_upd;
        logic cp_rd;
        logic cp_wr;
        logic sum_rd;
        logic sum_acc;
        logic mean_load;
        logic out_load;
    } agf_cmd_t;

    typedef struct packed {
        logic bypass;
        logic hit;
        logic last;
        logic overflow;
        logic out_free;
    } agf_status_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] hyst;
        logic                enable;
    } agf_cfg_t;

endpackage

[src/agf_regs.sv]
// Configuration registers of the ADC glitch filter behind an APB-style port.
// Depends on agf_pkg.
module agf_regs
    import agf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output agf_cfg_t              cfg
);

    logic [SAMPLE_W-1:0] hyst_reg;
    logic                enable_reg;
    logic                wr_en;
    logic                reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg   <= HYST_RESET;
            enable_reg <= ENABLE_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_HYST)
            begin
                hyst_reg <= pwdata[SAMPLE_W-1:0];
            end
            else
            begin
                enable_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_HYST:   prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, hyst_reg};
            REG_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}}, enable_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.hyst   = hyst_reg;
    assign cfg.enable = enable_reg;

endmodule

[src/agf_ctrl.sv]
// Controller state machine of the ADC glitch filter: sequences search,
// update, copy, summing and the mean. Depends on agf_pkg.
module agf_ctrl
    import agf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  agf_status_t status,
    output agf_cmd_t    cmd
);

    agf_state_t state_reg;
    agf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.bypass ? ST_DONE : ST_SRCH_RD;
            end
            ST_SRCH_RD:
            begin
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                if (status.hit)
                begin
                    state_next = ST_HIT;
                end
                else if (status.last)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_HIT:
            begin
                state_next = ST_DONE;
            end
            ST_MISS:
            begin
                state_next = status.overflow ? ST_CP_RD : ST_SUM_RD;
            end
            ST_CP_RD:
            begin
                state_next = ST_CP_WR;
            end
            ST_CP_WR:
            begin
                state_next = status.last ? ST_SUM_RD : ST_CP_RD;
            end
            ST_SUM_RD:
            begin
                state_next = ST_SUM_ACC;
            end
            ST_SUM_ACC:
            begin
                state_next = status.last ? ST_MEAN : ST_SUM_RD;
            end
            ST_MEAN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SRCH_RD:  cmd.srch_rd   = 1'b1;
            ST_SRCH_CMP: cmd.srch_next = ~status.hit;
            ST_HIT:      cmd.hit_upd   = 1'b1;
            ST_MISS:     cmd.miss_upd  = 1'b1;
            ST_CP_RD:    cmd.cp_rd     = 1'b1;
            ST_CP_WR:    cmd.cp_wr     = 1'b1;
            ST_SUM_RD:   cmd.sum_rd    = 1'b1;
            ST_SUM_ACC:  cmd.sum_acc   = 1'b1;
            ST_MEAN:     cmd.mean_load = 1'b1;
            ST_DONE:     cmd.out_load  = status.out_free;
            default:     cmd           = '0;
        endcase
    end

endmodule

[src/agf_dp.sv]
// Datapath of the ADC glitch filter: ring memories, per-channel position
// and count, sum accumulator, reciprocal multiply for the mean, output register.
// Depends on agf_pkg.
module agf_dp
    import agf_pkg::*;
#(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int RING_DEPTH = DEF_RING_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  agf_cfg_t            cfg,
    input  agf_cmd_t            cmd,
    output agf_status_t         status,
    input  logic [CHAN_W-1:0]   channel,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [SAMPLE_W-1:0] filtered_value
);

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW     = CH_W + IDX_W;
    localparam int MEM_D  = 1 << AW;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + IDX_W;
    localparam int PROD_W = 2 * SUM_W + 1;
    localparam int DIV_SH = SUM_W + IDX_W;
    localparam longint RECIP = ((longint'(1) << DIV_SH) + longint'(RING_DEPTH) - 1)
                               / longint'(RING_DEPTH);

    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(RING_DEPTH - 1);
    localparam logic [CNT_W:0]    CNT_LIMIT = (CNT_W + 1)'(RING_DEPTH);
    localparam logic [SUM_W:0]    RECIP_M   = (SUM_W + 1)'(RECIP);

    logic [CHAN_W-1:0]   ch_reg;
    logic [SAMPLE_W-1:0] smp_reg;
    logic [IDX_W-1:0]    p_reg;
    logic [IDX_W-1:0]    step_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] mean_reg;
    logic                use_mean_reg;
    logic [SAMPLE_W-1:0] out_value_reg;
    logic                out_valid_reg;

    logic [IDX_W-1:0]    pos_reg [CHANNELS];
    logic [CNT_W-1:0]    cnt_reg [CHANNELS];

    logic [SAMPLE_W-1:0] acc_mem [MEM_D];
    logic [SAMPLE_W-1:0] sus_mem [MEM_D];
    logic [MEM_D-1:0]    acc_vld_reg;
    logic [MEM_D-1:0]    sus_vld_reg;
    logic [SAMPLE_W-1:0] acc_q_reg;
    logic [SAMPLE_W-1:0] sus_q_reg;
    logic                acc_vq_reg;
    logic                sus_vq_reg;

    logic [CH_W-1:0]     cidx;
    logic [CH_W-1:0]     in_cidx;
    logic [AW-1:0]       acc_raddr;
    logic [AW-1:0]       acc_waddr;
    logic [AW-1:0]       sus_raddr;
    logic [AW-1:0]       sus_waddr;
    logic                acc_we;
    logic                sus_we;
    logic [SAMPLE_W-1:0] acc_wdata;
    logic [SAMPLE_W-1:0] acc_rd;
    logic [SAMPLE_W-1:0] sus_rd;
    logic [SAMPLE_W-1:0] diff;
    logic [IDX_W-1:0]    p_back;
    logic [IDX_W-1:0]    step_adv;
    logic [CNT_W-1:0]    cnt_cur;
    logic [CNT_W:0]      cnt_inc;
    logic                overflow;
    logic                last;
    logic [PROD_W-1:0]   prod;

    assign cidx    = ch_reg[CH_W-1:0];
    assign in_cidx = channel[CH_W-1:0];

    assign acc_rd = acc_vq_reg ? acc_q_reg : '0;
    assign sus_rd = sus_vq_reg ? sus_q_reg : '0;
    assign diff   = (smp_reg >= acc_rd) ? (smp_reg - acc_rd) : (acc_rd - smp_reg);

    assign last     = (step_reg == IDX_LAST);
    assign step_adv = last ? '0 : step_reg + 1'b1;
    assign p_back   = (p_reg == '0) ? IDX_LAST : p_reg - 1'b1;
    assign cnt_cur  = cnt_reg[cidx];
    assign cnt_inc  = {1'b0, cnt_cur} + 1'b1;
    assign overflow = (cnt_inc > CNT_LIMIT);

    assign prod = PROD_W'(sum_reg) * PROD_W'(RECIP_M);

    assign acc_raddr = cmd.srch_rd ? {cidx, p_reg} : {cidx, step_reg};
    assign acc_we    = cmd.hit_upd | cmd.cp_wr;
    assign acc_waddr = cmd.hit_upd ? {cidx, p_back} : {cidx, step_reg};
    assign acc_wdata = cmd.hit_upd ? smp_reg : sus_rd;
    assign sus_raddr = {cidx, step_reg};
    assign sus_we    = cmd.miss_upd & ~overflow;
    assign sus_waddr = {cidx, cnt_cur[IDX_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_q_reg  <= acc_mem[acc_raddr];
        acc_vq_reg <= acc_vld_reg[acc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sus_we)
        begin
            sus_mem[sus_waddr] <= smp_reg;
        end
        sus_q_reg  <= sus_mem[sus_raddr];
        sus_vq_reg <= sus_vld_reg[sus_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg   <= '0;
            sus_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                pos_reg[c] <= '0;
                cnt_reg[c] <= '0;
            end
        end
        else
        begin
            if (acc_we)
            begin
                acc_vld_reg[acc_waddr] <= 1'b1;
            end
            if (sus_we)
            begin
                sus_vld_reg[sus_waddr] <= 1'b1;
            end
            if (cmd.hit_upd)
            begin
                pos_reg[cidx] <= p_back;
                cnt_reg[cidx] <= '0;
            end
            if (cmd.miss_upd)
            begin
                cnt_reg[cidx] <= overflow ? '0 : cnt_inc[CNT_W-1:0];
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg       <= channel;
            smp_reg      <= sample;
            p_reg        <= pos_reg[in_cidx];
            step_reg     <= '0;
            use_mean_reg <= 1'b0;
        end
        if (cmd.srch_next)
        begin
            p_reg    <= (p_reg == IDX_LAST) ? '0 : p_reg + 1'b1;
            step_reg <= step_adv;
        end
        if (cmd.miss_upd)
        begin
            step_reg <= '0;
            sum_reg  <= '0;
        end
        if (cmd.cp_wr)
        begin
            step_reg <= step_adv;
        end
        if (cmd.sum_acc)
        begin
            sum_reg  <= sum_reg + SUM_W'(acc_rd);
            step_reg <= step_adv;
        end
        if (cmd.mean_load)
        begin
            mean_reg     <= prod[DIV_SH +: SAMPLE_W];
            use_mean_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_value_reg <= use_mean_reg ? mean_reg : smp_reg;
        end
    end

    assign status.bypass   = ~cfg.enable | (32'(ch_reg) >= CHANNELS);
    assign status.hit      = (diff <= cfg.hyst);
    assign status.last     = last;
    assign status.overflow = overflow;
    assign status.out_free = ~out_valid_reg | out_ready;

    assign out_valid      = out_valid_reg;
    assign filtered_value = out_value_reg;

endmodule

[src/adc_glitch_filter_unit.sv]
// Top level of the ADC glitch filter: APB registers, controller, datapath.
// Depends on agf_pkg, agf_regs, agf_ctrl and agf_dp.
//
// Usage: samples enter on the in channel (in_valid/in_ready, channel,
// sample); one filtered_value leaves on the out channel (out_valid/out_ready)
// per input transfer, in order. hysteresis and filter_enable sit at byte
// addresses 0 and 4 of the APB port; write them only while the block is idle.
// A sample bypasses the filter when it is off or its channel is out of range.
// Otherwise the ring is searched; a hit passes the sample through, a full
// miss outputs the ring mean, after copying the suspect ring in on overflow.
// Ring reads go through a registered read port per ring; the mean is the ring
// sum times a constant reciprocal of D = RING_DEPTH.
// One item is in work at a time; in_ready returns the cycle after the result
// is loaded into the output register, so the next item is taken while that
// result waits on a stalled receiver, and its own result waits for the slot.
// Reset clears all rings (per-entry valid bits), positions, counts and the
// output valid flag, and loads the register defaults.
module adc_glitch_filter_unit
    import agf_pkg::*;
#(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int RING_DEPTH = DEF_RING_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CHAN_W-1:0]     channel,
    input  logic [SAMPLE_W-1:0]   sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SAMPLE_W-1:0]   filtered_value
);

    agf_cfg_t    cfg;
    agf_cmd_t    cmd;
    agf_status_t status;

    agf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    agf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    agf_dp #(
        .CHANNELS   (CHANNELS),
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .channel        (channel),
        .sample         (sample),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .filtered_value (filtered_value)
    );

endmodule

[src/agf_checker.sv]
// Port-level checker for the ADC glitch filter, bound to the top level.
// Depends on agf_pkg and adc_glitch_filter_unit.
module agf_checker
    import agf_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                pready,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SAMPLE_W-1:0] filtered_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered_value))
        else $error("stalled result changed or dropped");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a transfer");

    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("new result without return to idle");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind adc_glitch_filter_unit agf_checker u_agf_checker (.*);
